// ----- hw/rtl/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the LAS point record decoder
// Register map, record layout, color offset table and queue item format.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned MIN_RECORD  = 12;
  localparam int unsigned COLOR_BYTES = 6;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_FORMAT   = 3'd0,
    REG_LENGTH   = 3'd1,
    REG_X_SCALE  = 3'd2,
    REG_Y_SCALE  = 3'd3,
    REG_Z_SCALE  = 3'd4,
    REG_X_OFFSET = 3'd5,
    REG_Y_OFFSET = 3'd6,
    REG_Z_OFFSET = 3'd7
  } reg_idx_t;

  // Color base offsets per record format
  localparam logic [5:0] COLOR_BASE_NONE = 6'd0;
  localparam logic [5:0] COLOR_BASE_F2   = 6'd20;
  localparam logic [5:0] COLOR_BASE_F3   = 6'd28;
  localparam logic [5:0] COLOR_BASE_F7   = 6'd30;

  localparam logic [15:0]        RESET_LENGTH = 16'd20;
  localparam logic signed [31:0] RESET_SCALE  = 32'sd16777216;  // 1.0 in Q.24

  typedef struct packed {
    logic [3:0]         record_format;
    logic [15:0]        record_length;
    logic signed [31:0] x_scale;
    logic signed [31:0] y_scale;
    logic signed [31:0] z_scale;
    logic signed [63:0] x_offset;
    logic signed [63:0] y_offset;
    logic signed [63:0] z_offset;
  } cfg_t;

  // One finished record, colors already gated
  typedef struct packed {
    logic signed [31:0] raw_x;
    logic signed [31:0] raw_y;
    logic signed [31:0] raw_z;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
  } rec_t;

  function automatic logic [5:0] color_base(input logic [3:0] fmt);
    logic [5:0] b;
    case (fmt) inside
      4'd2:               b = COLOR_BASE_F2;
      4'd3, 4'd5:         b = COLOR_BASE_F3;
      4'd7, 4'd8, 4'd10:  b = COLOR_BASE_F7;
      default:            b = COLOR_BASE_NONE;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/lpr_front.sv -----
// ----------------------------------------------------------------------------
// lpr_front: record assembly
// Tracks the byte position, places bytes into the coordinate and color words
// and hands a finished record to the queue at the last byte.
// ----------------------------------------------------------------------------
module lpr_front
  import lpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       start_of_data,
  output logic       push,
  output rec_t       push_rec
);

  logic [15:0]        pos_r, pos_nxt;
  logic signed [31:0] raw_x_r, raw_x_nxt;
  logic signed [31:0] raw_y_r, raw_y_nxt;
  logic signed [31:0] raw_z_r, raw_z_nxt;
  logic [15:0]        red_r, red_nxt;
  logic [15:0]        green_r, green_nxt;
  logic [15:0]        blue_r, blue_nxt;

  logic [15:0] pos;
  logic [15:0] len_eff;
  logic [5:0]  base;
  logic [15:0] rel;
  logic        in_color;
  logic        rec_end;
  logic        colors_ok;

  always_comb begin
    pos       = start_of_data ? 16'd0 : pos_r;
    len_eff   = (cfg.record_length < 16'(MIN_RECORD)) ? 16'(MIN_RECORD)
                                                       : cfg.record_length;
    base      = color_base(cfg.record_format);
    rel       = pos - 16'(base);
    in_color  = (base != COLOR_BASE_NONE) && (pos >= 16'(base)) &&
                (rel < 16'(COLOR_BYTES));
    rec_end   = ({1'b0, pos} + 17'd1) >= {1'b0, len_eff};
    colors_ok = (base != COLOR_BASE_NONE) &&
                ((17'(base) + 17'(COLOR_BYTES)) <= {1'b0, len_eff});

    raw_x_nxt = raw_x_r;
    raw_y_nxt = raw_y_r;
    raw_z_nxt = raw_z_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;

    if (pos < 16'd4) begin
      raw_x_nxt[{pos[1:0], 3'b000} +: 8] = data_byte;
    end else if (pos < 16'd8) begin
      raw_y_nxt[{pos[1:0], 3'b000} +: 8] = data_byte;
    end else if (pos < 16'(MIN_RECORD)) begin
      raw_z_nxt[{pos[1:0], 3'b000} +: 8] = data_byte;
    end else if (in_color) begin
      case (rel[2:1])
        2'd0:    red_nxt[{rel[0], 3'b000} +: 8]   = data_byte;
        2'd1:    green_nxt[{rel[0], 3'b000} +: 8] = data_byte;
        default: blue_nxt[{rel[0], 3'b000} +: 8]  = data_byte;
      endcase
    end

    pos_nxt = rec_end ? 16'd0 : pos + 16'd1;

    push           = accept && rec_end;
    push_rec.raw_x = raw_x_nxt;
    push_rec.raw_y = raw_y_nxt;
    push_rec.raw_z = raw_z_nxt;
    push_rec.red   = colors_ok ? red_nxt   : 16'd0;
    push_rec.green = colors_ok ? green_nxt : 16'd0;
    push_rec.blue  = colors_ok ? blue_nxt  : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      raw_x_r <= '0;
      raw_y_r <= '0;
      raw_z_r <= '0;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      raw_x_r <= raw_x_nxt;
      raw_y_r <= raw_y_nxt;
      raw_z_r <= raw_z_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule

// ----- hw/rtl/lpr_fifo.sv -----
// ----------------------------------------------------------------------------
// lpr_fifo: record queue
// Short queue of finished records between assembly and scaling.
// ----------------------------------------------------------------------------
module lpr_fifo
  import lpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  output logic not_empty,
  input  logic pop,
  output rec_t pop_rec
);

  rec_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;

  assign full      = count_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("record queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("record queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("record queue count out of range");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("record queue count missed a push");

endmodule

// ----- hw/rtl/lpr_back.sv -----
// ----------------------------------------------------------------------------
// lpr_back: scale and offset
// Multiply stage, then saturating add into the output register.
// ----------------------------------------------------------------------------
module lpr_back
  import lpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         rec_valid,
  input  rec_t         rec,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [239:0] out_data
);

  logic               mul_v_r;
  logic signed [63:0] prod_x_r, prod_y_r, prod_z_r;
  logic [15:0]        mred_r, mgreen_r, mblue_r;
  logic               o_v_r;
  logic signed [63:0] cx_r, cy_r, cz_r;
  logic [15:0]        ored_r, ogreen_r, oblue_r;

  logic               o_adv;
  logic               m_adv;
  logic signed [63:0] prod_x, prod_y, prod_z;
  logic signed [63:0] cx_nxt, cy_nxt, cz_nxt;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  assign o_adv = !o_v_r || out_ready;
  assign m_adv = !mul_v_r || o_adv;
  assign pop   = rec_valid && m_adv;

  assign prod_x = rec.raw_x * cfg.x_scale;
  assign prod_y = rec.raw_y * cfg.y_scale;
  assign prod_z = rec.raw_z * cfg.z_scale;

  assign cx_nxt = sat_add(prod_x_r, cfg.x_offset);
  assign cy_nxt = sat_add(prod_y_r, cfg.y_offset);
  assign cz_nxt = sat_add(prod_z_r, cfg.z_offset);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      o_v_r   <= 1'b0;
    end else begin
      if (m_adv) begin
        mul_v_r <= rec_valid;
      end
      if (o_adv) begin
        o_v_r <= mul_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prod_x_r <= prod_x;
      prod_y_r <= prod_y;
      prod_z_r <= prod_z;
      mred_r   <= rec.red;
      mgreen_r <= rec.green;
      mblue_r  <= rec.blue;
    end
    if (o_adv && mul_v_r) begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      cz_r     <= cz_nxt;
      ored_r   <= mred_r;
      ogreen_r <= mgreen_r;
      oblue_r  <= mblue_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = {oblue_r, ogreen_r, ored_r, cz_r, cy_r, cx_r};

endmodule

// ----- hw/rtl/las_point_record_decoder_core.sv -----
// ----------------------------------------------------------------------------
// las_point_record_decoder_core: LAS point record decoder
// Assembles fixed-length LAS point records from a byte stream and emits
// scaled, offset, saturated Q.24 coordinates plus raw RGB per record.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata: data_byte; tuser: start
//  out_    | out | out_tvalid / out_tready| tdata: x, y, z (64 b), r, g, b
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index (3 b), cfg_data (64 b)
//
//  One byte per cycle. After a record's last byte is taken, the queue is
//  written, then the record passes a 32x32 multiply stage and a saturating
//  add stage before out_tvalid rises.
//  The front stalls (in_tready low) only when the four-entry record queue is
//  full; the back stalls on out_tready and blocks assembly only once it fills.
//  rst_n clears position, assembled words, queue pointers and stage valids,
//  and loads register defaults. No clearing pass.
//  The user must write registers only while idle; the block does not
//  enforce it. cfg_ready is always high.
module las_point_record_decoder_core
  import lpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] start_of_data
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [239:0] out_tdata,  // [63:0] coord_x, [127:64] coord_y,
                                   // [191:128] coord_z, [207:192] red,
                                   // [223:208] green, [239:224] blue
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  cfg_t cfg_r;
  logic push, full, not_empty, pop;
  rec_t push_rec, pop_rec;
  logic accept;

  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.record_format <= '0;
      cfg_r.record_length <= RESET_LENGTH;
      cfg_r.x_scale       <= RESET_SCALE;
      cfg_r.y_scale       <= RESET_SCALE;
      cfg_r.z_scale       <= RESET_SCALE;
      cfg_r.x_offset      <= '0;
      cfg_r.y_offset      <= '0;
      cfg_r.z_offset      <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_FORMAT:   cfg_r.record_format <= cfg_data[3:0];
        REG_LENGTH:   cfg_r.record_length <= cfg_data[15:0];
        REG_X_SCALE:  cfg_r.x_scale       <= cfg_data[31:0];
        REG_Y_SCALE:  cfg_r.y_scale       <= cfg_data[31:0];
        REG_Z_SCALE:  cfg_r.z_scale       <= cfg_data[31:0];
        REG_X_OFFSET: cfg_r.x_offset      <= cfg_data;
        REG_Y_OFFSET: cfg_r.y_offset      <= cfg_data;
        REG_Z_OFFSET: cfg_r.z_offset      <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Byte is taken whenever the queue has room for a possible record end
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  lpr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .data_byte     (in_tdata),
    .start_of_data (in_tuser),
    .push          (push),
    .push_rec      (push_rec)
  );

  lpr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .full      (full),
    .not_empty (not_empty),
    .pop       (pop),
    .pop_rec   (pop_rec)
  );

  lpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_valid (not_empty),
    .rec       (pop_rec),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ----- tb/sv/lpr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_checker: scoreboard for the LAS point record decoder
// Watches the byte, result and register channels. Keeps its own copy of
// the registers and the record assembly state, works out the point that
// each closing byte should produce, and compares it with the block's
// results in order.
// ----------------------------------------------------------------------------
module lpr_checker
  import lpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [239:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } point_t;

  point_t expected_points[$];

  // register shadows
  logic [3:0]  fmt_q;
  logic [15:0] len_q;
  logic [31:0] scale_q [3];
  logic [63:0] offset_q[3];

  // assembly state
  logic [15:0] pos_q;
  logic [31:0] raw_q  [3];
  logic [15:0] color_q[3];

  int errors = 0;

  function automatic int unsigned color_offset(input logic [3:0] fmt);
    case (fmt)
      4'd2:              return COLOR_BASE_F2;
      4'd3, 4'd5:        return COLOR_BASE_F3;
      4'd7, 4'd8, 4'd10: return COLOR_BASE_F7;
      default:           return 0;
    endcase
  endfunction

  // raw * scale + offset, saturated to 64 bits signed
  function automatic logic [63:0] scaled(input logic [31:0] raw, input logic [31:0] scale,
                                         input logic [63:0] offset);
    logic [63:0] prod;
    logic [64:0] sum;
    prod = {{32{raw[31]}}, raw} * {{32{scale[31]}}, scale};
    sum  = {prod[63], prod} + {offset[63], offset};
    if (sum[64] != sum[63])
      return sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return sum[63:0];
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic sop);
    int unsigned len;
    int unsigned base;
    int unsigned p;
    bit          colors_ok;
    point_t      pt;
    if (sop) pos_q = '0;
    len = len_q;
    if (len < MIN_RECORD) len = MIN_RECORD;
    base      = color_offset(fmt_q);
    p         = pos_q;
    colors_ok = (base != 0) && (base + COLOR_BYTES <= len);
    if (p < 12)
      raw_q[p / 4][8 * (p % 4) +: 8] = b;
    else if (base != 0 && p >= base && p < base + COLOR_BYTES)
      color_q[(p - base) / 2][8 * ((p - base) % 2) +: 8] = b;
    if (p + 1 >= len) begin
      pos_q = '0;
      pt.x  = scaled(raw_q[0], scale_q[0], offset_q[0]);
      pt.y  = scaled(raw_q[1], scale_q[1], offset_q[1]);
      pt.z  = scaled(raw_q[2], scale_q[2], offset_q[2]);
      pt.r  = colors_ok ? color_q[0] : 16'h0;
      pt.g  = colors_ok ? color_q[1] : 16'h0;
      pt.b  = colors_ok ? color_q[2] : 16'h0;
      expected_points.push_back(pt);
    end else begin
      pos_q = p + 1;
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_point(input logic [239:0] data);
    point_t want;
    if (expected_points.size() == 0) begin
      errors++;
      $display("%0t: unexpected point, expected none actual %h", $time, data);
      return;
    end
    want = expected_points.pop_front();
    compare_field("coord_x", want.x, data[63:0]);
    compare_field("coord_y", want.y, data[127:64]);
    compare_field("coord_z", want.z, data[191:128]);
    compare_field("red",     64'(want.r), 64'(data[207:192]));
    compare_field("green",   64'(want.g), 64'(data[223:208]));
    compare_field("blue",    64'(want.b), 64'(data[239:224]));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fmt_q = '0;
      len_q = RESET_LENGTH;
      pos_q = '0;
      for (int k = 0; k < 3; k++) begin
        scale_q[k]  = RESET_SCALE;
        offset_q[k] = '0;
        raw_q[k]    = '0;
        color_q[k]  = '0;
      end
      expected_points.delete();
    end else begin
      if (out_tvalid && out_tready) check_point(out_tdata);
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_FORMAT:   fmt_q       = cfg_data[3:0];
          REG_LENGTH:   len_q       = cfg_data[15:0];
          REG_X_SCALE:  scale_q[0]  = cfg_data[31:0];
          REG_Y_SCALE:  scale_q[1]  = cfg_data[31:0];
          REG_Z_SCALE:  scale_q[2]  = cfg_data[31:0];
          REG_X_OFFSET: offset_q[0] = cfg_data;
          REG_Y_OFFSET: offset_q[1] = cfg_data;
          REG_Z_OFFSET: offset_q[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
    end
    pending    <= expected_points.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the LAS point record decoder
// Drives byte streams of point records under many register settings, with
// random gaps on the byte side and random stalls on the result side. The
// checker beside the block predicts and compares each point; this module
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
  import lpr_pkg::*;
;

  localparam int DRAIN_CYCLES = 8;       // pipeline is three deep
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 950;
  localparam int QUIET_AFTER  = 850;     // no gaps or stalls past this many items

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [239:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  int fail_count;
  int pending;

  int          items_sent   = 0;
  int          cycle_count  = 0;
  bit          jitter_on    = 1'b1;
  int unsigned in_gap_rate  = 0;   // out of 16, chance of a gap before an item
  int unsigned out_gap_rate = 0;   // out of 16, chance of a stall burst
  int unsigned stall_left   = 0;
  int unsigned cur_len      = RESET_LENGTH;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  las_point_record_decoder_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lpr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts on out_tready
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (jitter_on && $urandom_range(0, 15) < out_gap_rate) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // One byte item; tvalid stays high across back-to-back items
  task automatic send_byte(input logic [7:0] b, input logic sop);
    @(negedge clk);
    if (jitter_on && $urandom_range(0, 15) < in_gap_rate) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = sop;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    jitter_on = (items_sent < QUIET_AFTER);
  endtask

  // Stop sending, let all points come out, then give the pipe time to settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_LENGTH) cur_len = (val[15:0] < MIN_RECORD) ? MIN_RECORD : val[15:0];
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0:       return RESET_SCALE;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 64'h0;
      1:       return 64'h7FFF_FFFF_FFFF_FFFF;
      2:       return 64'h8000_0000_0000_0000;
      3:       return {{32{1'b0}}, $urandom} - 64'h8000_0000;  // near zero
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // len bytes; coordinate bytes built from whole words so extremes show up
  task automatic send_record(input int unsigned len, input bit mark);
    logic [31:0] w[3];
    logic [7:0]  b;
    for (int k = 0; k < 3; k++) w[k] = pick_coord();
    for (int i = 0; i < len; i++) begin
      b = (i < 12) ? w[i / 4][8 * (i % 4) +: 8] : 8'($urandom);
      send_byte(b, mark && (i == 0));
    end
  endtask

  // Formats that carry color
  function automatic int unsigned color_base_pick(input int unsigned n);
    case (n)
      0:       return 2;
      1:       return 3;
      2:       return 5;
      3:       return 7;
      4:       return 8;
      default: return 10;
    endcase
  endfunction

  // Random register setting for one phase
  task automatic program_phase();
    logic [3:0]  fmt;
    int unsigned base;
    int unsigned len_w;
    fmt  = $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                : 4'(color_base_pick($urandom_range(0, 5)));
    base = 32'(color_base(fmt));
    case ($urandom_range(0, 5))
      0:       len_w = 12 + $urandom_range(0, 4);
      1:       len_w = (base != 0) ? base + COLOR_BYTES : 20;
      2:       len_w = (base != 0) ? base + COLOR_BYTES - 1 : 13;  // colors don't fit
      3:       len_w = $urandom_range(0, 11);                      // below minimum
      default: len_w = $urandom_range(12, 48);
    endcase
    write_reg(REG_FORMAT,   64'(fmt));
    write_reg(REG_LENGTH,   {48'($urandom), 16'(len_w)});  // upper bits are don't-care
    write_reg(REG_X_SCALE,  {$urandom, pick_scale()});
    write_reg(REG_Y_SCALE,  {$urandom, pick_scale()});
    write_reg(REG_Z_SCALE,  {$urandom, pick_scale()});
    write_reg(REG_X_OFFSET, pick_offset());
    write_reg(REG_Y_OFFSET, pick_offset());
    write_reg(REG_Z_OFFSET, pick_offset());
  endtask

  initial begin
    int phase;
    int nrec;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: saturation both ways with extreme scales and offsets.
    // x: max * max + max clips high, y: min * max + min clips low,
    // z: min * min (= +2^62) + max clips high.
    write_reg(REG_LENGTH,   64'd12);
    write_reg(REG_X_SCALE,  64'h7FFF_FFFF);
    write_reg(REG_Y_SCALE,  64'h7FFF_FFFF);
    write_reg(REG_Z_SCALE,  64'h8000_0000);
    write_reg(REG_X_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(REG_Y_OFFSET, 64'h8000_0000_0000_0000);
    write_reg(REG_Z_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 12; i++)
      send_byte((i < 4) ? ((i == 3) ? 8'h7F : 8'hFF) : ((i % 4 == 3) ? 8'h80 : 8'h00),
                i == 0);
    // y times a one-lsb scale plus min offset clips low when y is negative
    wait_idle();
    write_reg(REG_Y_SCALE, 64'h0000_0001);
    write_reg(REG_Y_OFFSET, 64'h8000_0000_0000_0000);
    send_record(12, 1'b1);
    // start mark in the middle of a record drops the partial one
    send_record(3, 1'b1);
    send_record(12, 1'b1);
    wait_idle();

    // Random phases
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      in_gap_rate  = $urandom_range(0, 4);
      out_gap_rate = $urandom_range(0, 4);
      if (phase == 3) begin
        // longest record length with a partial record, then the length is lowered below the position reached
        write_reg(REG_FORMAT, 64'd10);
        write_reg(REG_LENGTH, 64'hFFFF);
        send_record(36, 1'b1);
        wait_idle();
        write_reg(REG_LENGTH, 64'd12);
        send_byte(8'($urandom), 1'b0);
      end else begin
        program_phase();
        nrec = (cur_len > 40) ? $urandom_range(1, 2) : $urandom_range(2, 6);
        for (int r = 0; r < nrec; r++) begin
          if ($urandom_range(0, 7) == 0) begin
            // broken record, restarted by a start mark
            send_record($urandom_range(1, cur_len - 1), 1'b1);
            send_record(cur_len, 1'b1);
          end else begin
            send_record(cur_len, (r == 0) || ($urandom_range(0, 3) == 0));
          end
        end
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
